// ===== hw/rtl/swpd_pkg.sv =====
// Shared types and constants for the sync-word packet deframer.
`default_nettype none

package swpd_pkg;

  // Sync word characters, in order of arrival.
  localparam logic [7:0] SYNC_W = 8'h57;
  localparam logic [7:0] SYNC_H = 8'h48;
  localparam logic [7:0] SYNC_O = 8'h4F;
  localparam logic [7:0] SYNC_P = 8'h50;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NODE_W  = 8;
  localparam logic [NODE_W-1:0] NODE_ID_RST = '0;

  // One byte handed from the input register to the parser.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } swpd_step_t;

  // One parser result, loaded into the output register.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] frame_word;
    logic              last_frame;
  } swpd_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swpd_in_reg.sv =====
// Input register stage that holds one received byte until the parser takes it.
`default_nettype none

module swpd_in_reg
  import swpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              advance,
  output swpd_step_t             step
);

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;

  // The stage refills in the same cycle that its byte moves on.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

  assign step.valid   = valid_r && advance;
  assign step.rx_byte = byte_r;

endmodule

`default_nettype wire

// ===== hw/rtl/swpd_parser.sv =====
// Packet parser state machine: sync hunt, destination check, frame count and frame assembly.
`default_nettype none

module swpd_parser
  import swpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire swpd_step_t        step,
  input  wire logic [NODE_W-1:0] own_node_id,
  output swpd_res_t              res
);

  typedef enum logic [3:0] {
    ST_HUNT  = 4'd0,
    ST_H     = 4'd1,
    ST_O1    = 4'd2,
    ST_O2    = 4'd3,
    ST_P     = 4'd4,
    ST_DEST  = 4'd5,
    ST_COUNT = 4'd6,
    ST_B1    = 4'd7,
    ST_B2    = 4'd8,
    ST_B3    = 4'd9,
    ST_B4    = 4'd10
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [7:0]        frames_r;
  logic [7:0]        frames_nxt;
  logic [23:0]       partial_r;
  logic [23:0]       partial_nxt;
  logic              emit;
  logic              last;
  logic [BYTE_W-1:0] b;

  assign b    = step.rx_byte;
  assign last = (frames_r <= 8'd1);

  // Next-state decode for one byte.
  always_comb begin
    state_nxt   = state_r;
    frames_nxt  = frames_r;
    partial_nxt = partial_r;
    emit        = 1'b0;
    unique case (state_r)
      ST_H:     state_nxt = (b == SYNC_H) ? ST_O1 : ST_HUNT;
      ST_O1:    state_nxt = (b == SYNC_O) ? ST_O2 : ST_HUNT;
      ST_O2:    state_nxt = (b == SYNC_O) ? ST_P : ST_HUNT;
      ST_P:     state_nxt = (b == SYNC_P) ? ST_DEST : ST_HUNT;
      ST_DEST:  state_nxt = (b == own_node_id) ? ST_COUNT : ST_HUNT;
      ST_COUNT: begin
        if (b != '0) begin
          frames_nxt = b;
          state_nxt  = ST_B1;
        end else begin
          state_nxt = ST_HUNT;
        end
      end
      ST_B1: begin
        partial_nxt[23:16] = b;
        state_nxt          = ST_B2;
      end
      ST_B2: begin
        partial_nxt[15:8] = b;
        state_nxt         = ST_B3;
      end
      ST_B3: begin
        partial_nxt[7:0] = b;
        state_nxt        = ST_B4;
      end
      ST_B4: begin
        emit = 1'b1;
        if (last) begin
          frames_nxt = '0;
          state_nxt  = ST_HUNT;
        end else begin
          frames_nxt = frames_r - 8'd1;
          state_nxt  = ST_B1;
        end
      end
      // Hunt state; unused codes behave the same way.
      default:  state_nxt = (b == SYNC_W) ? ST_H : ST_HUNT;
    endcase
  end

  // State and counters advance only when a byte is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT;
      frames_r <= '0;
    end else if (step.valid) begin
      state_r  <= state_nxt;
      frames_r <= frames_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid) begin
      partial_r <= partial_nxt;
    end
  end

  assign res.valid      = step.valid && emit;
  assign res.frame_word = {partial_r, b};
  assign res.last_frame = last;

  // While frame bytes are gathered, at least one frame is still owed.
  a_frames_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_B1 || state_r == ST_B2 || state_r == ST_B3 || state_r == ST_B4)
      |-> frames_r != 8'd0)
    else $error("frame count is zero during frame assembly");

  // The last frame of a packet returns the parser to the hunt.
  a_last_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.last_frame) |=> (state_r == ST_HUNT && frames_r == 8'd0))
    else $error("parser did not return to hunt after last frame");

  // A result that is not the last one leads into the next frame.
  a_more_to_b1: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res.last_frame) |=> (state_r == ST_B1 && frames_r == $past(frames_r) - 8'd1))
    else $error("parser did not start the next frame");

endmodule

`default_nettype wire

// ===== hw/rtl/swpd_out_reg.sv =====
// Output register that holds one frame word until the downstream side takes it.
`default_nettype none

module swpd_out_reg
  import swpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire swpd_res_t         res,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_word,
  output logic                   out_last
);

  logic              valid_r;
  logic              valid_nxt;
  logic [WORD_W-1:0] word_r;
  logic              last_r;

  // The register can load whenever it is empty or being drained.
  assign advance   = !valid_r || out_ready;
  assign valid_nxt = advance ? res.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      word_r <= res.frame_word;
      last_r <= res.last_frame;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sync_word_packet_deframer_core.sv =====
// A frame word reaches the output via the input register and then the output register.
// Throughput: one byte per cycle unless the output stalls; stages refill as they drain.
// The parse state machine decides each byte combinationally between input and output registers.
// Reset (rst_n, synchronous, active low) empties both stages, sends the parser to the
// sync hunt, clears the frame count and sets the own node id to zero.
`default_nettype none

module sync_word_packet_deframer_core
  import swpd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Received byte stream.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] rx_byte
  // Frame word stream.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [31:0]            out_tdata,  // [31:0] frame_word
  output logic                   out_tlast,  // last_frame
  // Own node id write channel.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [NODE_W-1:0] cfg_data    // [7:0] own_node_id
);

  logic [NODE_W-1:0] own_node_id_r;
  logic              advance;
  swpd_step_t        step;
  swpd_res_t         res;

  // The configuration register takes every transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_node_id_r <= NODE_ID_RST;
    end else if (cfg_valid && cfg_ready) begin
      own_node_id_r <= cfg_data;
    end
  end

  swpd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .advance  (advance),
    .step     (step)
  );

  swpd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .own_node_id (own_node_id_r),
    .res         (res)
  );

  swpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_tdata),
    .out_last  (out_tlast)
  );

  // A full output register that is stalled blocks the parser.
  a_stall_blocks_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !step.valid)
    else $error("parser stepped while output was stalled");

  // Input back-pressure only comes from a stalled output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

  // A result only appears after a parser step.
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(step.valid))
    else $error("output valid without a parser step");

endmodule

`default_nettype wire
